// File: sv/x86d_pkg.sv
`timescale 1ns / 1ps
// Package: types, codes and decode helpers for the x86 subset decoder.
package x86d_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ESCAPE = 3'd1,
        PH_MODRM  = 3'd2,
        PH_SIB    = 3'd3,
        PH_DISP   = 3'd4,
        PH_IMM    = 3'd5
    } t_phase;

    localparam logic [5:0] K_UD     = 6'd0;
    localparam logic [5:0] K_UNIMPL = 6'd1;
    localparam logic [5:0] K_ALU    = 6'd2;
    localparam logic [5:0] K_MOVSX  = 6'd3;
    localparam logic [5:0] K_MOVZX  = 6'd4;
    localparam logic [5:0] K_PUSH   = 6'd5;
    localparam logic [5:0] K_POP    = 6'd6;
    localparam logic [5:0] K_JCC    = 6'd7;
    localparam logic [5:0] K_MOV    = 6'd8;
    localparam logic [5:0] K_LEA    = 6'd9;
    localparam logic [5:0] K_XCHG   = 6'd10;
    localparam logic [5:0] K_NOP    = 6'd11;
    localparam logic [5:0] K_PUSHF  = 6'd12;
    localparam logic [5:0] K_POPF   = 6'd13;
    localparam logic [5:0] K_SHIFT  = 6'd14;
    localparam logic [5:0] K_RET    = 6'd15;
    localparam logic [5:0] K_LEAVE  = 6'd16;
    localparam logic [5:0] K_INT    = 6'd17;
    localparam logic [5:0] K_IRETQ  = 6'd18;
    localparam logic [5:0] K_IN     = 6'd19;
    localparam logic [5:0] K_OUT    = 6'd20;
    localparam logic [5:0] K_CALL   = 6'd21;
    localparam logic [5:0] K_JMP    = 6'd22;
    localparam logic [5:0] K_HLT    = 6'd23;
    localparam logic [5:0] K_UNARY  = 6'd24;
    localparam logic [5:0] K_MULDIV = 6'd25;
    localparam logic [5:0] K_FLAG   = 6'd26;
    localparam logic [5:0] K_CMOV   = 6'd27;
    localparam logic [5:0] K_DESC   = 6'd28;
    localparam logic [5:0] K_MOVCR  = 6'd29;
    localparam logic [5:0] K_WRMSR  = 6'd30;
    localparam logic [5:0] K_RDMSR  = 6'd31;
    localparam logic [5:0] K_SETCC  = 6'd32;
    localparam logic [5:0] K_CPUID  = 6'd33;

    localparam logic [2:0] FM_NONE    = 3'd0;
    localparam logic [2:0] FM_RM_REG  = 3'd1;
    localparam logic [2:0] FM_REG_RM  = 3'd2;
    localparam logic [2:0] FM_ACC_IMM = 3'd3;
    localparam logic [2:0] FM_RM_IMM  = 3'd4;

    localparam logic [7:0] OP_ESC  = 8'h0f;
    localparam logic [7:0] PFX_OS  = 8'h66;
    localparam logic [7:0] PFX_AS  = 8'h67;
    localparam logic [7:0] PFX_LCK = 8'hf0;

    // Raw instruction record handed from the parser to the classifier.
    typedef struct packed {
        logic        trunc;
        logic [4:0]  count;     // saturates at 16
        logic        os16;
        logic        as32;
        logic        lock;
        logic [7:0]  rex;
        logic [7:0]  opcode;
        logic        two_byte;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [31:0] disp;
        logic [63:0] imm;
    } t_raw;

    typedef struct packed {
        logic        status;
        logic [3:0]  length;
        logic [5:0]  op_class;
        logic [3:0]  sub_op;
        logic [3:0]  operand_size;
        logic [2:0]  source_size;
        logic [2:0]  operand_form;
        logic [3:0]  reg_number;
        logic [3:0]  rm_number;
        logic [39:0] decode_flags;
        logic [31:0] displacement;
        logic [63:0] immediate;
    } t_res;

    function automatic logic is_pfx(input logic [7:0] b);
        case (b) inside
            8'h66, 8'h67, 8'hf0, 8'hf2, 8'hf3, 8'h26, 8'h2e, 8'h36, 8'h3e,
            8'h64, 8'h65, [8'h40:8'h4f]: is_pfx = 1'b1;
            default: is_pfx = 1'b0;
        endcase
    endfunction

    function automatic logic needs_modrm(input logic [7:0] op, input logic tb);
        if (tb) begin
            case (op) inside
                8'h01, 8'h1f, 8'h20, 8'h22, [8'h40:8'h4f], [8'h90:8'h9f],
                8'haf, 8'hb6, 8'hb7, 8'hbe, 8'hbf: needs_modrm = 1'b1;
                default: needs_modrm = 1'b0;
            endcase
        end else if (op <= 8'h3f) begin
            needs_modrm = (op[2:0] <= 3'd3);
        end else begin
            case (op) inside
                8'h63, [8'h80:8'h8b], 8'h8d, 8'h8f, 8'hc0, 8'hc1, 8'hc6, 8'hc7,
                [8'hd0:8'hd3], 8'hf6, 8'hf7, 8'hfe, 8'hff: needs_modrm = 1'b1;
                default: needs_modrm = 1'b0;
            endcase
        end
    endfunction

    function automatic logic [3:0] base_os(input logic rw, input logic os16);
        base_os = rw ? 4'd8 : (os16 ? 4'd2 : 4'd4);
    endfunction

    function automatic logic [3:0] disp_len(input logic [7:0] m, input logic [7:0] s);
        case (m[7:6])
            2'd3: disp_len = 4'd0;
            2'd1: disp_len = 4'd1;
            2'd2: disp_len = 4'd4;
            default: begin
                if (m[2:0] == 3'd4) disp_len = (s[2:0] == 3'd5) ? 4'd4 : 4'd0;
                else disp_len = (m[2:0] == 3'd5) ? 4'd4 : 4'd0;
            end
        endcase
    endfunction

    function automatic logic [3:0] imm_len(input logic [7:0] op, input logic tb,
                                           input logic [7:0] m, input logic rw,
                                           input logic os16);
        logic [3:0] os;
        logic [3:0] wd;
        os = base_os(rw, os16);
        wd = (os == 4'd8) ? 4'd4 : os;
        imm_len = 4'd0;
        if (tb) begin
            imm_len = (op[7:4] == 4'h8) ? 4'd4 : 4'd0;
        end else if (op <= 8'h3f) begin
            if (op[2:0] == 3'd4) imm_len = 4'd1;
            else if (op[2:0] == 3'd5) imm_len = wd;
        end else begin
            case (op) inside
                8'h68: imm_len = os16 ? 4'd2 : 4'd4;
                8'h81, 8'ha9: imm_len = wd;
                8'h6a, [8'h70:8'h7f], 8'h80, 8'h82, 8'h83, 8'ha8, [8'hb0:8'hb7],
                8'hc0, 8'hc1, 8'hcd, [8'he4:8'he7], 8'heb: imm_len = 4'd1;
                [8'hb8:8'hbf]: imm_len = os;
                8'hc2: imm_len = 4'd2;
                8'he8, 8'he9: imm_len = 4'd4;
                8'hc6, 8'hf6: imm_len = (m[5:3] == 3'd0) ? 4'd1 : 4'd0;
                8'hc7, 8'hf7: imm_len = (m[5:3] == 3'd0) ? wd : 4'd0;
                default: imm_len = 4'd0;
            endcase
        end
    endfunction

endpackage

// File: sv/x86d_if.sv
`timescale 1ns / 1ps
// Interfaces: byte input channel and decoded result channel.
interface x86d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_available;
    modport source (output valid, output byte_value, output last_available, input ready);
    modport sink   (input valid, input byte_value, input last_available, output ready);
endinterface

interface x86d_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [3:0]  length;
    logic [5:0]  op_class;
    logic [3:0]  sub_op;
    logic [3:0]  operand_size;
    logic [2:0]  source_size;
    logic [2:0]  operand_form;
    logic [3:0]  reg_number;
    logic [3:0]  rm_number;
    logic [39:0] decode_flags;
    logic signed [31:0] displacement;
    logic [63:0] immediate;
    modport source (output valid, output status, output length, output op_class,
                    output sub_op, output operand_size, output source_size,
                    output operand_form, output reg_number, output rm_number,
                    output decode_flags, output displacement, output immediate,
                    input ready);
    modport sink   (input valid, input status, input length, input op_class,
                    input sub_op, input operand_size, input source_size,
                    input operand_form, input reg_number, input rm_number,
                    input decode_flags, input displacement, input immediate,
                    output ready);
endinterface

// File: sv/x86d_front.sv
`timescale 1ns / 1ps
// Front end: byte parser that assembles one raw instruction record.
module x86d_front #(
    parameter int MAX_PREFIXES = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_ready,
    output logic                o_rec_valid,
    output x86d_pkg::t_raw      o_rec,
    input  logic                i_rec_ready
);
    x86d_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_count;
    logic        r_os16, r_as32, r_lock, r_tb;
    logic [7:0]  r_rex, r_op, r_modrm, r_sib;
    logic [31:0] r_disp;
    logic [63:0] r_imm;
    logic [3:0]  r_rem;
    logic [1:0]  r_dk;
    logic [2:0]  r_ik;

    logic        fire, done, rst_rec;
    logic [4:0]  cnt;
    logic [7:0]  op_v, m_v, s_v;
    logic        tb_v;
    logic [3:0]  il, dl, n_rem;
    logic        os16_v, as32_v, lock_v;
    logic [7:0]  rex_v;
    logic [31:0] disp_v;
    logic [63:0] imm_v;

    assign o_ready = i_rec_ready;
    assign fire    = i_valid & o_ready;
    assign cnt     = (r_count <= 5'd15) ? r_count + 5'd1 : r_count;

    always_comb begin
        n_phase = r_phase;
        done    = 1'b0;
        op_v = r_op; tb_v = r_tb; m_v = r_modrm; s_v = r_sib;
        os16_v = r_os16; as32_v = r_as32; lock_v = r_lock; rex_v = r_rex;
        disp_v = r_disp; imm_v = r_imm; n_rem = r_rem;
        il = 4'd0; dl = 4'd0;
        case (r_phase)
            x86d_pkg::PH_PREFIX: begin
                if (cnt <= 5'(MAX_PREFIXES) && x86d_pkg::is_pfx(i_byte)) begin
                    if (i_byte == x86d_pkg::PFX_OS) os16_v = 1'b1;
                    else if (i_byte == x86d_pkg::PFX_AS) as32_v = 1'b1;
                    else if (i_byte == x86d_pkg::PFX_LCK) lock_v = 1'b1;
                    rex_v = (i_byte[7:4] == 4'h4) ? i_byte : 8'h00;
                end else if (i_byte == x86d_pkg::OP_ESC) begin
                    n_phase = x86d_pkg::PH_ESCAPE;
                end else begin
                    op_v = i_byte; tb_v = 1'b0;
                end
            end
            x86d_pkg::PH_ESCAPE: begin
                op_v = i_byte; tb_v = 1'b1;
            end
            x86d_pkg::PH_MODRM: begin
                m_v = i_byte;
                if (i_byte[7:6] != 2'd3 && i_byte[2:0] == 3'd4) n_phase = x86d_pkg::PH_SIB;
            end
            x86d_pkg::PH_SIB: s_v = i_byte;
            x86d_pkg::PH_DISP: begin
                case (r_dk)
                    2'd0: disp_v[7:0]   = i_byte;
                    2'd1: disp_v[15:8]  = i_byte;
                    2'd2: disp_v[23:16] = i_byte;
                    default: disp_v[31:24] = i_byte;
                endcase
                n_rem = r_rem - 4'd1;
            end
            x86d_pkg::PH_IMM: begin
                imm_v = r_imm | (64'(i_byte) << {r_ik, 3'b000});
                n_rem = r_rem - 4'd1;
            end
            default: n_phase = x86d_pkg::PH_PREFIX;
        endcase
        il = x86d_pkg::imm_len(op_v, tb_v, m_v, rex_v[3], os16_v);
        dl = x86d_pkg::disp_len(m_v, s_v);
        // Onward chaining: opcode -> modrm -> address -> immediate.
        case (r_phase)
            x86d_pkg::PH_PREFIX, x86d_pkg::PH_ESCAPE: begin
                if (n_phase == r_phase || r_phase == x86d_pkg::PH_ESCAPE) begin
                    if (!(r_phase == x86d_pkg::PH_PREFIX && (op_v != i_byte || tb_v
                          || (cnt <= 5'(MAX_PREFIXES) && x86d_pkg::is_pfx(i_byte))))) begin
                        if (x86d_pkg::needs_modrm(op_v, tb_v)) n_phase = x86d_pkg::PH_MODRM;
                        else if (il != 4'd0) begin
                            n_phase = x86d_pkg::PH_IMM; n_rem = il;
                        end else done = 1'b1;
                    end
                end
            end
            x86d_pkg::PH_MODRM, x86d_pkg::PH_SIB: begin
                if (r_phase == x86d_pkg::PH_SIB || n_phase != x86d_pkg::PH_SIB) begin
                    if (dl != 4'd0) begin
                        n_phase = x86d_pkg::PH_DISP; n_rem = dl;
                    end else if (il != 4'd0) begin
                        n_phase = x86d_pkg::PH_IMM; n_rem = il;
                    end else done = 1'b1;
                end
            end
            x86d_pkg::PH_DISP: begin
                if (n_rem == 4'd0) begin
                    if (il != 4'd0) begin
                        n_phase = x86d_pkg::PH_IMM; n_rem = il;
                    end else done = 1'b1;
                end
            end
            x86d_pkg::PH_IMM: if (n_rem == 4'd0) done = 1'b1;
            default: ;
        endcase
    end

    assign rst_rec = done | i_last;

    always_comb begin
        o_rec          = '0;
        o_rec.trunc    = ~done;
        o_rec.count    = cnt;
        if (done) begin
            o_rec.os16 = os16_v; o_rec.as32 = as32_v; o_rec.lock = lock_v;
            o_rec.rex = rex_v; o_rec.opcode = op_v; o_rec.two_byte = tb_v;
            o_rec.modrm = m_v; o_rec.sib = s_v; o_rec.disp = disp_v; o_rec.imm = imm_v;
        end
    end
    assign o_rec_valid = fire & rst_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= x86d_pkg::PH_PREFIX;
            r_count <= '0; r_os16 <= 1'b0; r_as32 <= 1'b0; r_lock <= 1'b0;
            r_rex <= '0; r_tb <= 1'b0; r_disp <= '0; r_imm <= '0; r_rem <= '0;
            r_dk <= '0; r_ik <= '0;
        end else if (fire) begin
            if (rst_rec) begin
                r_phase <= x86d_pkg::PH_PREFIX;
                r_count <= '0; r_os16 <= 1'b0; r_as32 <= 1'b0; r_lock <= 1'b0;
                r_rex <= '0; r_tb <= 1'b0; r_disp <= '0; r_imm <= '0; r_rem <= '0;
                r_dk <= '0; r_ik <= '0;
            end else begin
                r_phase <= n_phase; r_count <= cnt;
                r_os16 <= os16_v; r_as32 <= as32_v; r_lock <= lock_v; r_rex <= rex_v;
                r_tb <= tb_v; r_disp <= disp_v; r_imm <= imm_v; r_rem <= n_rem;
                r_dk <= (n_phase == x86d_pkg::PH_DISP && r_phase != x86d_pkg::PH_DISP)
                        ? 2'd0 : r_dk + 2'(r_phase == x86d_pkg::PH_DISP);
                r_ik <= (n_phase == x86d_pkg::PH_IMM && r_phase != x86d_pkg::PH_IMM)
                        ? 3'd0 : r_ik + 3'(r_phase == x86d_pkg::PH_IMM);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_op <= op_v; r_modrm <= m_v; r_sib <= s_v;
        end
    end
endmodule

// File: sv/x86d_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of raw instruction records between parser and classifier.
module x86d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  x86d_pkg::t_raw i_data,
    output logic           o_ready,
    output logic           o_valid,
    output x86d_pkg::t_raw o_data,
    input  logic           i_ready
);
    x86d_pkg::t_raw r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid & o_ready;
    assign rd = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

// File: sv/x86d_back.sv
`timescale 1ns / 1ps
// Back end: classifies a raw record into the result fields, registered output.
module x86d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  x86d_pkg::t_raw i_rec,
    output logic           o_ready,
    output logic           o_valid,
    output x86d_pkg::t_res o_res,
    input  logic           i_ready
);
    x86d_pkg::t_res r_res, res;
    logic r_valid;

    always_comb begin
        logic [7:0] op;
        logic [2:0] lo, dg, rmf, bf, xf;
        logic rw, rr, rx, rb, hm, sib, hdisp, rip, nobase, noidx;
        logic acc, isrc, ronly, shimm, shcl;
        logic [1:0] md, scale;
        logic [3:0] reg_n, rm_n, base, idx, dl, il, os, stk, sub;
        logic [2:0] src, form;
        logic [5:0] cls;
        logic [31:0] disp;
        logic [63:0] imm;
        op = i_rec.opcode; lo = op[2:0];
        rw = i_rec.rex[3]; rr = i_rec.rex[2]; rx = i_rec.rex[1]; rb = i_rec.rex[0];
        hm = x86d_pkg::needs_modrm(op, i_rec.two_byte);
        md = 2'd0; dg = 3'd0; reg_n = 4'd0; rm_n = 4'd0; scale = 2'd0; base = 4'd0;
        idx = 4'd0; sib = 1'b0; hdisp = 1'b0; rip = 1'b0; nobase = 1'b0; noidx = 1'b0;
        dl = 4'd0; rmf = i_rec.modrm[2:0]; bf = i_rec.sib[2:0]; xf = i_rec.sib[5:3];
        il = x86d_pkg::imm_len(op, i_rec.two_byte, i_rec.modrm, rw, i_rec.os16);
        os = x86d_pkg::base_os(rw, i_rec.os16);
        src = 3'd0; form = x86d_pkg::FM_NONE; cls = x86d_pkg::K_UD; sub = 4'd0;
        acc = 1'b0; isrc = 1'b0; ronly = 1'b0; shimm = 1'b0; shcl = 1'b0;
        stk = i_rec.os16 ? 4'd2 : 4'd8;
        imm = i_rec.imm;
        if (hm) begin
            md = i_rec.modrm[7:6]; dg = i_rec.modrm[5:3];
            reg_n = {rr, dg}; rm_n = {rb, rmf};
            if (md != 2'd3 && rmf == 3'd4) begin
                sib = 1'b1; scale = i_rec.sib[7:6];
                base = {rb, bf}; idx = {rx, xf};
                noidx = (xf == 3'd4) && !rx;
                nobase = (md == 2'd0) && (bf == 3'd5);
            end
            dl = x86d_pkg::disp_len(i_rec.modrm, i_rec.sib);
            hdisp = (dl != 4'd0);
            rip = (md == 2'd0) && !sib && (rmf == 3'd5) && !i_rec.as32;
        end
        disp = i_rec.disp;
        if (dl == 4'd1) disp = {{24{i_rec.disp[7]}}, i_rec.disp[7:0]};

        if (!i_rec.two_byte) begin
            case (op) inside
                [8'h00:8'h3f]: begin
                    if (lo <= 3'd5) begin
                        cls = x86d_pkg::K_ALU; sub = {1'b0, op[5:3]};
                        if (!lo[0]) os = 4'd1;
                        form = (lo <= 3'd1) ? x86d_pkg::FM_RM_REG :
                               (lo <= 3'd3) ? x86d_pkg::FM_REG_RM : x86d_pkg::FM_ACC_IMM;
                        acc = (lo >= 3'd4);
                    end
                end
                8'h63: begin cls = x86d_pkg::K_MOVSX; src = 3'd4; os = rw ? 4'd8 : 4'd4; end
                [8'h50:8'h5f]: begin
                    cls = (op < 8'h58) ? x86d_pkg::K_PUSH : x86d_pkg::K_POP;
                    os = stk; ronly = 1'b1; rm_n = {rb, lo};
                end
                8'h68, 8'h6a: begin cls = x86d_pkg::K_PUSH; isrc = 1'b1; os = stk; end
                [8'h70:8'h7f]: begin cls = x86d_pkg::K_JCC; sub = op[3:0]; end
                [8'h80:8'h83]: begin
                    cls = x86d_pkg::K_ALU; form = x86d_pkg::FM_RM_IMM; sub = {1'b0, dg};
                    if (op == 8'h80) os = 4'd1;
                end
                8'h84, 8'h85: begin
                    cls = x86d_pkg::K_ALU; sub = 4'd8; form = x86d_pkg::FM_RM_REG;
                    if (!op[0]) os = 4'd1;
                end
                8'h86, 8'h87: begin cls = x86d_pkg::K_XCHG; if (!op[0]) os = 4'd1; end
                [8'h88:8'h8b]: begin
                    cls = x86d_pkg::K_MOV; if (!op[0]) os = 4'd1;
                    form = op[1] ? x86d_pkg::FM_REG_RM : x86d_pkg::FM_RM_REG;
                end
                8'h8d: begin cls = x86d_pkg::K_LEA; form = x86d_pkg::FM_REG_RM; end
                8'h8f: begin cls = x86d_pkg::K_POP; os = stk; end
                [8'h90:8'h97]: begin
                    if (op == 8'h90 && !rb) cls = x86d_pkg::K_NOP;
                    else begin
                        cls = x86d_pkg::K_XCHG; hm = 1'b1; md = 2'd3; reg_n = 4'd0;
                        rm_n = {rb, lo};
                    end
                end
                8'h98: begin
                    cls = x86d_pkg::K_MOVSX; ronly = 1'b1; rm_n = 4'd0; md = 2'd3;
                    src = rw ? 3'd4 : (i_rec.os16 ? 3'd1 : 3'd2);
                end
                8'h9c: begin cls = x86d_pkg::K_PUSHF; os = stk; end
                8'h9d: begin cls = x86d_pkg::K_POPF; os = stk; end
                8'ha8, 8'ha9: begin
                    cls = x86d_pkg::K_ALU; sub = 4'd8; form = x86d_pkg::FM_ACC_IMM; acc = 1'b1;
                    if (!op[0]) os = 4'd1;
                end
                [8'hb0:8'hbf]: begin
                    cls = x86d_pkg::K_MOV; ronly = 1'b1; rm_n = {rb, lo};
                    if (op < 8'hb8) os = 4'd1;
                end
                8'hc0, 8'hc1, [8'hd0:8'hd3]: begin
                    if (!op[0]) os = 4'd1;
                    if (dg == 3'd2 || dg == 3'd3 || dg == 3'd6) cls = x86d_pkg::K_UNIMPL;
                    else begin cls = x86d_pkg::K_SHIFT; sub = {1'b0, dg}; end
                    if (op <= 8'hc1) shimm = 1'b1;
                    else if (op >= 8'hd2) shcl = 1'b1;
                    else imm = 64'd1;
                end
                8'hc2, 8'hc3: cls = x86d_pkg::K_RET;
                8'hc6, 8'hc7: begin
                    if (!op[0]) os = 4'd1;
                    if (dg == 3'd0) begin cls = x86d_pkg::K_MOV; form = x86d_pkg::FM_RM_IMM; end
                end
                8'hc9: cls = x86d_pkg::K_LEAVE;
                8'hcc: begin cls = x86d_pkg::K_INT; imm = 64'd3; end
                8'hcd: cls = x86d_pkg::K_INT;
                8'hcf: cls = x86d_pkg::K_IRETQ;
                [8'he4:8'he7]: begin
                    cls = (op <= 8'he5) ? x86d_pkg::K_IN : x86d_pkg::K_OUT;
                    if (!op[0]) os = 4'd1;
                    isrc = 1'b1;
                end
                [8'hec:8'hef]: begin
                    cls = (op <= 8'hed) ? x86d_pkg::K_IN : x86d_pkg::K_OUT;
                    if (!op[0]) os = 4'd1;
                end
                8'he8: cls = x86d_pkg::K_CALL;
                8'he9, 8'heb: cls = x86d_pkg::K_JMP;
                8'hf4: cls = x86d_pkg::K_HLT;
                8'hf6, 8'hf7: begin
                    if (!op[0]) os = 4'd1;
                    if (dg == 3'd0) begin
                        cls = x86d_pkg::K_ALU; sub = 4'd8; form = x86d_pkg::FM_RM_IMM;
                    end else if (dg == 3'd2 || dg == 3'd3) begin
                        cls = x86d_pkg::K_UNARY; sub = {1'b0, dg};
                    end else if (dg >= 3'd4) begin
                        cls = x86d_pkg::K_MULDIV; sub = {2'b00, dg[1:0]};
                    end
                end
                [8'hf8:8'hfd]: begin cls = x86d_pkg::K_FLAG; sub = {1'b0, lo}; end
                8'hfe, 8'hff: begin
                    if (!op[0]) os = 4'd1;
                    if (dg <= 3'd1) begin cls = x86d_pkg::K_UNARY; sub = {1'b0, dg}; end
                    else if (op[0] && dg == 3'd2) begin cls = x86d_pkg::K_CALL; os = 4'd8; end
                    else if (op[0] && dg == 3'd4) begin cls = x86d_pkg::K_JMP; os = 4'd8; end
                    else if (op[0] && dg == 3'd6) begin cls = x86d_pkg::K_PUSH; os = stk; end
                end
                default: ;
            endcase
        end else begin
            case (op) inside
                [8'h40:8'h4f]: begin cls = x86d_pkg::K_CMOV; sub = op[3:0]; end
                8'h01: begin
                    if (md == 2'd3) cls = x86d_pkg::K_UD;
                    else if (dg <= 3'd3) begin cls = x86d_pkg::K_DESC; sub = {1'b0, dg}; end
                    else cls = x86d_pkg::K_UNIMPL;
                end
                8'h20, 8'h22: begin
                    cls = x86d_pkg::K_MOVCR; os = 4'd8; sub = {3'b000, ~op[1]};
                end
                8'h30: cls = x86d_pkg::K_WRMSR;
                8'h32: cls = x86d_pkg::K_RDMSR;
                8'h1f: cls = x86d_pkg::K_NOP;
                [8'h80:8'h8f]: begin cls = x86d_pkg::K_JCC; sub = op[3:0]; end
                [8'h90:8'h9f]: begin cls = x86d_pkg::K_SETCC; sub = op[3:0]; os = 4'd1; end
                8'ha2: cls = x86d_pkg::K_CPUID;
                8'haf: begin cls = x86d_pkg::K_MULDIV; sub = 4'd4; end
                8'hb6, 8'hb7, 8'hbe, 8'hbf: begin
                    cls = (op <= 8'hb7) ? x86d_pkg::K_MOVZX : x86d_pkg::K_MOVSX;
                    src = op[0] ? 3'd2 : 3'd1;
                end
                default: ;
            endcase
        end
        if (i_rec.count[4]) cls = x86d_pkg::K_UD;

        res = '0;
        res.length = i_rec.count[4] ? 4'd15 : i_rec.count[3:0];
        if (i_rec.trunc) begin
            res.status = 1'b1;
        end else begin
            res.op_class = cls; res.sub_op = sub; res.operand_size = os;
            res.source_size = src; res.operand_form = form;
            res.reg_number = reg_n; res.rm_number = rm_n;
            res.decode_flags = {5'd0, i_rec.os16, i_rec.as32, shcl, shimm, ronly, isrc,
                                acc, il, (i_rec.rex != 8'h00), rb, rx, rr, rw,
                                i_rec.lock, noidx, nobase, rip, hdisp, sib, hm,
                                idx, base, scale, md};
            res.displacement = disp; res.immediate = imm;
        end
    end

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_ready) r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_res <= res;
    end
endmodule

// File: sv/x86_64_subset_instruction_decoder.sv
`timescale 1ns / 1ps
// Top level of the streaming x86-64 subset instruction decoder.
//
// Usage: instruction bytes arrive one beat at a time on i_in (valid/ready,
// byte_value plus last_available). The parser in the front end tracks the
// prefix, opcode, ModRM, SIB, displacement and immediate phases and, on the
// byte that completes an instruction (or on a last_available byte that does
// not), pushes one raw record into a two-entry queue. The back end classifies
// the record and holds the result in an output register on o_out.
// Throughput: one byte per cycle while the queue has space; the parser
// updates its phase registers once per beat. The record enters the queue
// as the final byte is taken; the back end then loads the result into the
// output register, from which it is offered on o_out. Truncation gives status 1
// with the byte count and all other fields zero; over-long instructions report
// class undefined with length 15.
// Reset: i_rst_n synchronous, active low; the parser returns to the prefix
// phase and queue and output register empty.
// Stall: when o_out is not taken the output register holds, the queue fills,
// and input ready falls only once the queue has no space left.
module x86_64_subset_instruction_decoder #(
    parameter int MAX_PREFIXES = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    x86d_in_if.sink           i_in,
    x86d_out_if.source        o_out
);
    logic           rec_valid, rec_ready, q_valid, q_ready;
    x86d_pkg::t_raw rec, q_data;
    x86d_pkg::t_res res;

    x86d_front #(.MAX_PREFIXES(MAX_PREFIXES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .i_byte(i_in.byte_value), .i_last(i_in.last_available),
        .o_ready(i_in.ready), .o_rec_valid(rec_valid), .o_rec(rec), .i_rec_ready(rec_ready)
    );

    x86d_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(rec_valid), .i_data(rec), .o_ready(rec_ready),
        .o_valid(q_valid), .o_data(q_data), .i_ready(q_ready)
    );

    x86d_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_rec(q_data), .o_ready(q_ready),
        .o_valid(o_out.valid), .o_res(res), .i_ready(o_out.ready)
    );

    assign o_out.status       = res.status;
    assign o_out.length       = res.length;
    assign o_out.op_class     = res.op_class;
    assign o_out.sub_op       = res.sub_op;
    assign o_out.operand_size = res.operand_size;
    assign o_out.source_size  = res.source_size;
    assign o_out.operand_form = res.operand_form;
    assign o_out.reg_number   = res.reg_number;
    assign o_out.rm_number    = res.rm_number;
    assign o_out.decode_flags = res.decode_flags;
    assign o_out.displacement = $signed(res.displacement);
    assign o_out.immediate    = res.immediate;
endmodule
